[hdl/tbsf_pkg.sv]
// ----------------------------------------------------------------------------
// tbsf_pkg
// Shared types and constants of the truss bar stress, force and mass block.
// ----------------------------------------------------------------------------
package tbsf_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;
    localparam int RES_W          = 48;
    localparam int IN_TDATA_W     = 312;
    localparam int OUT_TDATA_W    = 144;
    localparam int ACC_W          = 100;
    localparam int MUL_W          = 34;
    localparam int LEN2_W         = 66;
    localparam int NUM_W          = 82;
    localparam int ROOT_W         = 33;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_LEN = 2'd1;
    localparam logic [1:0] STAT_SAT      = 2'd2;

    // One multiply-accumulate step of the shared multiplier.
    typedef enum logic [3:0] {
        ST_LEN_X, ST_LEN_Y, ST_LEN_Z,
        ST_DOT_X, ST_DOT_Y, ST_DOT_Z,
        ST_STR_LO, ST_STR_HI,
        ST_FRC_LO, ST_FRC_HI,
        ST_DA,
        ST_MASS_LO, ST_MASS_HI
    } t_step;

    typedef enum logic [2:0] {
        S_IDLE, S_DIFF, S_MUL, S_ACC, S_CHECK, S_ITER, S_OUT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  read;
        logic  diff;
        logic  mul;
        logic  acc;
        t_step step;
        logic  iter_start;
        logic  out_load;
        logic  out_zero;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic iter_done;
    } t_stat;

endpackage

[hdl/tbsf_ctrl.sv]
// ----------------------------------------------------------------------------
// tbsf_ctrl
// Sequencer: point loads, multiply steps, divide/root wait, result handoff.
// ----------------------------------------------------------------------------
module tbsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_action,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  tbsf_pkg::t_stat i_stat,
    output tbsf_pkg::t_cmd  o_cmd
);

    tbsf_pkg::t_state r_state, n_state;
    tbsf_pkg::t_step  r_step, n_step;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbsf_pkg::S_IDLE;
            r_step      <= tbsf_pkg::ST_LEN_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_s_tready  = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tbsf_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (!i_action) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.read = 1'b1;
                        n_state    = tbsf_pkg::S_DIFF;
                    end
                end
            end
            tbsf_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_step     = tbsf_pkg::ST_LEN_X;
                n_state    = tbsf_pkg::S_MUL;
            end
            tbsf_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = tbsf_pkg::S_ACC;
            end
            tbsf_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_step == tbsf_pkg::ST_DOT_Z) begin
                    n_state = tbsf_pkg::S_CHECK;
                end else if (r_step == tbsf_pkg::ST_MASS_HI) begin
                    n_state = tbsf_pkg::S_OUT;
                end else begin
                    n_step  = tbsf_pkg::t_step'(r_step + 4'd1);
                    n_state = tbsf_pkg::S_MUL;
                end
            end
            tbsf_pkg::S_CHECK: begin
                if (i_stat.len_zero) begin
                    n_state = tbsf_pkg::S_OUT;
                end else begin
                    o_cmd.iter_start = 1'b1;
                    n_state          = tbsf_pkg::S_ITER;
                end
            end
            tbsf_pkg::S_ITER: begin
                if (i_stat.iter_done) begin
                    n_step  = tbsf_pkg::ST_STR_LO;
                    n_state = tbsf_pkg::S_MUL;
                end
            end
            tbsf_pkg::S_OUT: begin
                // The result register may be refilled in the cycle it is taken.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = i_stat.len_zero;
                    n_out_valid    = 1'b1;
                    n_state        = tbsf_pkg::S_IDLE;
                end
            end
            default: n_state = tbsf_pkg::S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

[hdl/tbsf_dp.sv]
// ----------------------------------------------------------------------------
// tbsf_dp
// Datapath: point store, shared multiplier with accumulator, divider, root.
// ----------------------------------------------------------------------------
module tbsf_dp #(
    parameter int MAX_POINTS = tbsf_pkg::DEF_MAX_POINTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tbsf_pkg::t_cmd               i_cmd,
    output tbsf_pkg::t_stat              o_stat,
    input  logic [tbsf_pkg::IDX_W-1:0]   i_first_point,
    input  logic [tbsf_pkg::IDX_W-1:0]   i_second_point,
    input  logic [6*tbsf_pkg::VAL_W-1:0] i_point,
    input  logic [tbsf_pkg::VAL_W-1:0]   i_stiffness,
    input  logic [tbsf_pkg::VAL_W-1:0]   i_cross_area,
    input  logic [tbsf_pkg::VAL_W-1:0]   i_density,
    output logic [tbsf_pkg::RES_W-1:0]   o_stress,
    output logic [tbsf_pkg::RES_W-1:0]   o_axial_force,
    output logic [tbsf_pkg::RES_W-1:0]   o_bar_mass,
    output logic [1:0]                   o_status
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int VW   = tbsf_pkg::VAL_W;
    localparam int AccW = tbsf_pkg::ACC_W;
    localparam int MW   = tbsf_pkg::MUL_W;
    localparam int LW   = tbsf_pkg::LEN2_W;
    localparam int NW   = tbsf_pkg::NUM_W;
    localparam int RW   = tbsf_pkg::ROOT_W;
    localparam int RsW  = tbsf_pkg::RES_W;
    localparam logic [RsW-1:0] POS_LIM  = {1'b0, {(RsW-1){1'b1}}};
    localparam logic [RsW-1:0] NEG_LIM  = {1'b1, {(RsW-1){1'b0}}};
    localparam logic [RsW-1:0] MASS_LIM = {RsW{1'b1}};

    logic [6*VW-1:0] r_mem [MAX_POINTS];
    logic [6*VW-1:0] r_rd0, r_rd1;
    logic            r_ok0, r_ok1;
    logic [VW-1:0]   r_mod, r_area, r_dens;

    logic [31:0]     w_a32, w_b32;
    logic [AW-1:0]   w_aa, w_ab;
    logic            w_a_ok, w_b_ok;

    assign w_a32  = 32'(i_first_point);
    assign w_b32  = 32'(i_second_point);
    assign w_aa   = w_a32[AW-1:0];
    assign w_ab   = w_b32[AW-1:0];
    assign w_a_ok = w_a32 < 32'(MAX_POINTS);
    assign w_b_ok = w_b32 < 32'(MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_a_ok) begin
            r_mem[w_aa] <= i_point;
        end
        if (i_cmd.read) begin
            r_rd0  <= r_mem[w_aa];
            r_rd1  <= r_mem[w_ab];
            r_ok0  <= w_a_ok;
            r_ok1  <= w_b_ok;
            r_mod  <= i_stiffness;
            r_area <= i_cross_area;
            r_dens <= i_density;
        end
    end

    // Differences are kept as sign and magnitude for the unsigned multiplier.
    logic [VW:0] r_dmag [3], r_umag [3];
    logic        r_dneg [3], r_uneg [3];
    logic [VW:0] w_dmag [3], w_umag [3];
    logic        w_dneg [3], w_uneg [3];

    always_comb begin
        logic [VW-1:0] p0, p1, q0, q1;
        logic [VW:0]   d, u;
        for (int k = 0; k < 3; k++) begin
            p0 = r_ok0 ? r_rd0[k*VW +: VW] : '0;
            p1 = r_ok1 ? r_rd1[k*VW +: VW] : '0;
            q0 = r_ok0 ? r_rd0[(k+3)*VW +: VW] : '0;
            q1 = r_ok1 ? r_rd1[(k+3)*VW +: VW] : '0;
            d  = {p1[VW-1], p1} - {p0[VW-1], p0};
            u  = {q1[VW-1], q1} - {q0[VW-1], q0};
            w_dneg[k] = d[VW];
            w_uneg[k] = u[VW];
            w_dmag[k] = d[VW] ? (~d + 1'b1) : d;
            w_umag[k] = u[VW] ? (~u + 1'b1) : u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            for (int k = 0; k < 3; k++) begin
                r_dmag[k] <= w_dmag[k];
                r_umag[k] <= w_umag[k];
                r_dneg[k] <= w_dneg[k];
                r_uneg[k] <= w_uneg[k];
            end
        end
    end

    logic [LW-1:0]     r_len2;
    logic [LW-1:0]     r_absdot;
    logic              r_dot_neg;
    logic [NW-1:0]     r_dq;
    logic [LW-1:0]     r_drem;
    logic [6:0]        r_dcnt;
    logic              r_div_busy;
    logic [LW-1:0]     r_sn;
    logic [RW-1:0]     r_sres;
    logic [RW+1:0]     r_srem;
    logic [5:0]        r_scnt;
    logic              r_sqrt_busy;
    logic [RsW-1:0]    r_smag, r_fmag, r_mass;
    logic              r_sneg, r_sat;
    logic [2*VW-1:0]   r_da;
    logic [2*MW-1:0]   r_prod;
    logic [AccW-1:0]   r_acc;

    logic [2*VW-1:0]   w_qc;
    assign w_qc = (|r_dq[NW-1:2*VW]) ? {(2*VW){1'b1}} : r_dq[2*VW-1:0];

    // Operand selection of the shared multiplier.
    logic [MW-1:0] w_ma, w_mb;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.step)
            tbsf_pkg::ST_LEN_X:   begin w_ma = MW'(r_dmag[0]); w_mb = MW'(r_dmag[0]); end
            tbsf_pkg::ST_LEN_Y:   begin w_ma = MW'(r_dmag[1]); w_mb = MW'(r_dmag[1]); end
            tbsf_pkg::ST_LEN_Z:   begin w_ma = MW'(r_dmag[2]); w_mb = MW'(r_dmag[2]); end
            tbsf_pkg::ST_DOT_X:   begin w_ma = MW'(r_umag[0]); w_mb = MW'(r_dmag[0]); end
            tbsf_pkg::ST_DOT_Y:   begin w_ma = MW'(r_umag[1]); w_mb = MW'(r_dmag[1]); end
            tbsf_pkg::ST_DOT_Z:   begin w_ma = MW'(r_umag[2]); w_mb = MW'(r_dmag[2]); end
            tbsf_pkg::ST_STR_LO:  begin w_ma = MW'(w_qc[VW-1:0]); w_mb = MW'(r_mod); end
            tbsf_pkg::ST_STR_HI:  begin w_ma = MW'(w_qc[2*VW-1:VW]); w_mb = MW'(r_mod); end
            tbsf_pkg::ST_FRC_LO:  begin w_ma = MW'(r_smag[VW-1:0]); w_mb = MW'(r_area); end
            tbsf_pkg::ST_FRC_HI:  begin w_ma = MW'(r_smag[RsW-1:VW]); w_mb = MW'(r_area); end
            tbsf_pkg::ST_DA:      begin w_ma = MW'(r_dens); w_mb = MW'(r_area); end
            tbsf_pkg::ST_MASS_LO: begin w_ma = MW'(r_da[VW-1:0]); w_mb = MW'(r_sres); end
            tbsf_pkg::ST_MASS_HI: begin w_ma = MW'(r_da[2*VW-1:VW]); w_mb = MW'(r_sres); end
            default:              begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_ma * w_mb;
        end
    end

    logic            w_clr, w_hi, w_neg;
    logic [AccW-1:0] w_term, w_base, n_acc;
    always_comb begin
        w_clr = 1'b0;
        w_hi  = 1'b0;
        w_neg = 1'b0;
        case (i_cmd.step) inside
            tbsf_pkg::ST_LEN_X, tbsf_pkg::ST_STR_LO, tbsf_pkg::ST_FRC_LO,
            tbsf_pkg::ST_DA, tbsf_pkg::ST_MASS_LO: w_clr = 1'b1;
            tbsf_pkg::ST_DOT_X: begin w_clr = 1'b1; w_neg = r_uneg[0] ^ r_dneg[0]; end
            tbsf_pkg::ST_DOT_Y: w_neg = r_uneg[1] ^ r_dneg[1];
            tbsf_pkg::ST_DOT_Z: w_neg = r_uneg[2] ^ r_dneg[2];
            tbsf_pkg::ST_STR_HI, tbsf_pkg::ST_FRC_HI, tbsf_pkg::ST_MASS_HI: w_hi = 1'b1;
            default: w_clr = 1'b0;
        endcase
        w_term = w_hi ? (AccW'(r_prod) << VW) : AccW'(r_prod);
        w_base = w_clr ? '0 : r_acc;
        n_acc  = w_neg ? (w_base - w_term) : (w_base + w_term);
    end

    // Saturation of the scaled products.
    logic [AccW-1:0] w_m16, w_m32, w_absacc;
    logic [RsW-1:0]  w_slim, w_flim;
    logic            w_ssat, w_fsat, w_msat;
    assign w_m16    = n_acc >> 16;
    assign w_m32    = n_acc >> 32;
    assign w_absacc = n_acc[AccW-1] ? (~n_acc + 1'b1) : n_acc;
    assign w_slim   = r_dot_neg ? NEG_LIM : POS_LIM;
    assign w_flim   = r_sneg ? NEG_LIM : POS_LIM;
    assign w_ssat   = w_m16 > AccW'(w_slim);
    assign w_fsat   = w_m16 > AccW'(w_flim);
    assign w_msat   = w_m32 > AccW'(MASS_LIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_sat <= 1'b0;
        end
        if (i_cmd.acc) begin
            r_acc <= n_acc;
            case (i_cmd.step)
                tbsf_pkg::ST_LEN_Z: r_len2 <= n_acc[LW-1:0];
                tbsf_pkg::ST_DOT_Z: begin
                    r_dot_neg <= n_acc[AccW-1];
                    r_absdot  <= w_absacc[LW-1:0];
                end
                tbsf_pkg::ST_STR_HI: begin
                    r_smag <= w_ssat ? w_slim : w_m16[RsW-1:0];
                    r_sneg <= r_dot_neg && (w_ssat || (w_m16[RsW-1:0] != '0));
                    r_sat  <= r_sat | w_ssat;
                end
                tbsf_pkg::ST_FRC_HI: begin
                    r_fmag <= w_fsat ? w_flim : w_m16[RsW-1:0];
                    r_sat  <= r_sat | w_fsat;
                end
                tbsf_pkg::ST_DA: r_da <= n_acc[2*VW-1:0];
                tbsf_pkg::ST_MASS_HI: begin
                    r_mass <= w_msat ? MASS_LIM : w_m32[RsW-1:0];
                    r_sat  <= r_sat | w_msat;
                end
                default: begin
                end
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle; quotient shifts into r_dq.
    logic [LW:0] w_dtry, w_dsub;
    assign w_dtry = {r_drem, r_dq[NW-1]};
    assign w_dsub = w_dtry - {1'b0, r_len2};

    // Digit-by-digit square root, two radicand bits per cycle.
    logic [RW+3:0] w_stry, w_strial, w_ssub;
    assign w_stry   = {r_srem, r_sn[LW-1:LW-2]};
    assign w_strial = {2'b00, r_sres, 2'b01};
    assign w_ssub   = w_stry - w_strial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy  <= 1'b0;
            r_sqrt_busy <= 1'b0;
        end else begin
            if (i_cmd.iter_start) begin
                r_dq        <= {r_absdot, 16'b0};
                r_drem      <= '0;
                r_dcnt      <= 7'(NW);
                r_div_busy  <= 1'b1;
                r_sn        <= r_len2;
                r_sres      <= '0;
                r_srem      <= '0;
                r_scnt      <= 6'(RW);
                r_sqrt_busy <= 1'b1;
            end else begin
                if (r_div_busy) begin
                    if (w_dtry >= {1'b0, r_len2}) begin
                        r_drem <= w_dsub[LW-1:0];
                        r_dq   <= {r_dq[NW-2:0], 1'b1};
                    end else begin
                        r_drem <= w_dtry[LW-1:0];
                        r_dq   <= {r_dq[NW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd1) begin
                        r_div_busy <= 1'b0;
                    end
                end
                if (r_sqrt_busy) begin
                    if (w_stry >= w_strial) begin
                        r_srem <= w_ssub[RW+1:0];
                        r_sres <= {r_sres[RW-2:0], 1'b1};
                    end else begin
                        r_srem <= w_stry[RW+1:0];
                        r_sres <= {r_sres[RW-2:0], 1'b0};
                    end
                    r_sn   <= r_sn << 2;
                    r_scnt <= r_scnt - 6'd1;
                    if (r_scnt == 6'd1) begin
                        r_sqrt_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_stat.len_zero  = (r_len2 == '0);
    assign o_stat.iter_done = !r_div_busy && !r_sqrt_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                o_stress      <= '0;
                o_axial_force <= '0;
                o_bar_mass    <= '0;
                o_status      <= tbsf_pkg::STAT_ZERO_LEN;
            end else begin
                o_stress      <= r_sneg ? (~r_smag + 1'b1) : r_smag;
                o_axial_force <= (r_sneg && r_fmag != '0) ? (~r_fmag + 1'b1) : r_fmag;
                o_bar_mass    <= r_mass;
                o_status      <= r_sat ? tbsf_pkg::STAT_SAT : tbsf_pkg::STAT_OK;
            end
        end
    end

endmodule

[hdl/truss_bar_stress_force_mass.sv]
// A point load gives no result; loads can follow back to back.
// A bar runs the read, differences, six multiply steps and the zero check, then waits on
// the 82-step radix-2 divider (root beside it), then runs seven multiply steps and the
// result load; a zero-length bar goes from the zero check straight to the result load.
// The next item is taken in the cycle after the result load; a waiting result holds the next bar at its load.
// Synchronous active-low reset clears control only; the point store is not cleared.
// ----------------------------------------------------------------------------
// truss_bar_stress_force_mass
// Axial stress, force and mass of a truss bar from a store of points.
// ----------------------------------------------------------------------------
module truss_bar_stress_force_mass #(
    parameter int MAX_POINTS = tbsf_pkg::DEF_MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_point, second_point, pos_x, pos_y, pos_z, disp_x, disp_y, disp_z,
    // stiffness, cross_area, density, zero pad
    input  logic [tbsf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // action
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // stress, axial_force, bar_mass
    output logic [tbsf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                          m_tuser
);

    tbsf_pkg::t_cmd  w_cmd;
    tbsf_pkg::t_stat w_stat;

    tbsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_action   (s_tuser[0]),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tbsf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_first_point     (s_tdata[9:0]),
        .i_second_point    (s_tdata[19:10]),
        .i_point           (s_tdata[211:20]),
        .i_stiffness       (s_tdata[243:212]),
        .i_cross_area      (s_tdata[275:244]),
        .i_density         (s_tdata[307:276]),
        .o_stress          (m_tdata[47:0]),
        .o_axial_force     (m_tdata[95:48]),
        .o_bar_mass        (m_tdata[143:96]),
        .o_status          (m_tuser)
    );

endmodule

[hdl/tbsf_checker.sv]
// ----------------------------------------------------------------------------
// tbsf_checker
// Port-level checks of the truss bar block, bound to the top level.
// ----------------------------------------------------------------------------
module tbsf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [tbsf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tbsf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]                       m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("bar transfer did not make the block busy");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == tbsf_pkg::STAT_ZERO_LEN |-> m_tdata == '0)
        else $error("zero-length bar gave nonzero fields");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser == tbsf_pkg::STAT_OK || m_tuser == tbsf_pkg::STAT_ZERO_LEN
                  || m_tuser == tbsf_pkg::STAT_SAT)
        else $error("undefined status code");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind truss_bar_stress_force_mass tbsf_checker u_tbsf_checker (.*);
